[rtl/dlefr_pkg.sv]
// Shared types, line codes and the CRC-16 byte update for the DLE frame builder.
// No dependencies; imported by every module of the block.
package dlefr_pkg;

   localparam int CfgCount = 8;
   localparam int AddrWidth = 5;
   localparam int HdrCount = 10;

   localparam logic [7:0] DleByte = 8'h10;
   localparam logic [7:0] StxByte = 8'h02;
   localparam logic [7:0] EtxByte = 8'h03;
   localparam logic [15:0] CrcPoly = 16'h1021;
   localparam logic [15:0] LenBias = 16'd10;

   localparam logic ActStart = 1'b0;
   localparam logic ActData = 1'b1;

   typedef struct packed {
      logic action;
      logic [15:0] payload_length;
      logic [7:0] command_override;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic run_last;
      logic frame_done;
      logic misuse_error;
   } rsp_payload_type;

   typedef logic [CfgCount-1:0][7:0] cfg_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/dlefr_csr.sv]
// Configuration register file for the DLE frame builder: eight header bytes on an APB-style port.
// Depends on dlefr_pkg.
module dlefr_csr
   import dlefr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output cfg_type              cfg
);

   cfg_type regs_ff;
   cfg_type regs_in;
   logic [2:0] index;

   assign index = csr_paddr[AddrWidth-1:2];

   always_comb begin
      regs_in = regs_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         regs_in[index] = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_prdata = {24'h000000, regs_ff[index]};
   assign csr_pready = 1'b1;
   assign cfg = regs_ff;

endmodule

[rtl/dlefr_seq.sv]
// Frame sequencer: walks one request through its line bytes, stuffs DLE, runs the CRC,
// and holds the result register. Depends on dlefr_pkg.
module dlefr_seq
   import dlefr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  req_payload_type item,
   input  logic            item_valid,
   output logic            load,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   input  logic            rsp_stall
);

   localparam logic [3:0] StIdle   = 4'd0;
   localparam logic [3:0] StSoh    = 4'd1;
   localparam logic [3:0] StStx    = 4'd2;
   localparam logic [3:0] StHdr    = 4'd3;
   localparam logic [3:0] StData   = 4'd4;
   localparam logic [3:0] StCrcHi  = 4'd5;
   localparam logic [3:0] StCrcLo  = 4'd6;
   localparam logic [3:0] StEndDle = 4'd7;
   localparam logic [3:0] StEtx    = 4'd8;
   localparam logic [3:0] StErr    = 4'd9;
   localparam logic [3:0] HdrLast  = 4'(HdrCount - 1);

   logic [3:0] state_ff, state_in;
   logic [3:0] hdr_ff, hdr_in;
   logic dup_ff, dup_in;
   logic open_ff, open_in;
   logic close_ff, close_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] len_ff, len_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] data_ff, data_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic can_load, emit, stuffable, feeds, repeat_byte, last, open_after;
   logic [7:0] cur_byte, hdr_byte;
   logic [3:0] adv_state;

   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign emit = (state_ff != StIdle) && can_load;

   always_comb begin
      case (hdr_ff)
         4'd0: hdr_byte = len_ff[15:8];
         4'd1: hdr_byte = len_ff[7:0];
         HdrLast: hdr_byte = cmd_ff;
         default: hdr_byte = cfg[3'(hdr_ff - 4'd2)];
      endcase
   end

   always_comb begin
      case (state_ff)
         StSoh: cur_byte = DleByte;
         StStx: cur_byte = StxByte;
         StHdr: cur_byte = hdr_byte;
         StData: cur_byte = data_ff;
         StCrcHi: cur_byte = crc_ff[15:8];
         StCrcLo: cur_byte = crc_ff[7:0];
         StEndDle: cur_byte = DleByte;
         StEtx: cur_byte = EtxByte;
         default: cur_byte = 8'h00;
      endcase
   end

   assign stuffable = state_ff inside {StHdr, StData, StCrcHi, StCrcLo};
   assign feeds = (state_ff == StHdr || state_ff == StData) && !dup_ff;
   assign repeat_byte = stuffable && (cur_byte == DleByte) && !dup_ff;

   always_comb begin
      if (repeat_byte) begin
         adv_state = state_ff;
      end else begin
         case (state_ff)
            StSoh: adv_state = StStx;
            StStx: adv_state = StHdr;
            StHdr: adv_state = (hdr_ff != HdrLast) ? StHdr : (close_ff ? StCrcHi : StIdle);
            StData: adv_state = close_ff ? StCrcHi : StIdle;
            StCrcHi: adv_state = StCrcLo;
            StCrcLo: adv_state = StEndDle;
            StEndDle: adv_state = StEtx;
            default: adv_state = StIdle;
         endcase
      end
   end

   assign last = (adv_state == StIdle);
   assign load = item_valid && ((state_ff == StIdle) || (emit && last));
   assign open_after = (emit && state_ff == StEtx) ? 1'b0 : open_ff;

   always_comb begin
      state_in = state_ff;
      hdr_in = hdr_ff;
      dup_in = dup_ff;
      open_in = open_ff;
      close_in = close_ff;
      rem_in = rem_ff;
      crc_in = crc_ff;
      len_in = len_ff;
      cmd_in = cmd_ff;
      data_in = data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in.out_byte = cur_byte;
         rsp_payload_in.run_last = last;
         rsp_payload_in.frame_done = (state_ff == StEtx);
         rsp_payload_in.misuse_error = (state_ff == StErr);
         state_in = adv_state;
         dup_in = repeat_byte;
         open_in = open_after;
         if (state_ff == StHdr && !repeat_byte) begin
            hdr_in = hdr_ff + 4'd1;
         end
         if (feeds) begin
            crc_in = crc16_byte(crc_ff, cur_byte);
         end
      end else if (can_load) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         dup_in = 1'b0;
         hdr_in = 4'd0;
         if (item.action == ActStart) begin
            state_in = StSoh;
            crc_in = 16'h0000;
            open_in = 1'b1;
            rem_in = item.payload_length;
            close_in = (item.payload_length == 16'h0000);
            len_in = item.payload_length + LenBias;
            cmd_in = (item.command_override != 8'h00) ? item.command_override : cfg[CfgCount-1];
         end else if (open_after) begin
            state_in = StData;
            rem_in = rem_ff - 16'd1;
            close_in = (rem_ff == 16'd1);
            data_in = item.data_byte;
         end else begin
            state_in = StErr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         hdr_ff <= 4'd0;
         dup_ff <= 1'b0;
         open_ff <= 1'b0;
         close_ff <= 1'b0;
         rem_ff <= 16'h0000;
         crc_ff <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hdr_ff <= hdr_in;
         dup_ff <= dup_in;
         open_ff <= open_in;
         close_ff <= close_in;
         rem_ff <= rem_in;
         crc_ff <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      cmd_ff <= cmd_in;
      data_ff <= data_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_dup_follows_dle: assert property (@(posedge clock) disable iff (reset)
      dup_ff |-> (rsp_valid_ff && rsp_payload_ff.out_byte == DleByte))
      else $error("stuffing repeat pending without a DLE in the result register");

   a_done_is_etx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.frame_done) |->
      (rsp_payload_ff.out_byte == EtxByte && rsp_payload_ff.run_last))
      else $error("frame close reported on a wrong byte or not as the last byte");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.misuse_error) |->
      (rsp_payload_ff.run_last && rsp_payload_ff.out_byte == 8'h00))
      else $error("misuse result is not a single zero byte");

   a_load_starts_work: assert property (@(posedge clock) disable iff (reset)
      load |=> (state_ff != StIdle && !dup_ff && hdr_ff == 4'd0))
      else $error("loaded request did not start the sequencer");
`endif

endmodule

[rtl/dle_framer_byte_stuff_crc16.sv]
// The first line byte of a request passes the input register, the sequencer state and the
// result register. Throughput: one line byte per cycle while rsp is not stalled; a start
// request sends DLE STX and the header, a payload byte its data; closing adds CRC, DLE, ETX.
// One request waits in the input register while the previous one is still being sent.
// Reset (synchronous, active high) clears the header registers, the frame state and the CRC.
// Top level: input register, register file and frame sequencer. Depends on dlefr_pkg.
module dle_framer_byte_stuff_crc16
   import dlefr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   cfg_type cfg;
   req_payload_type item_ff, item_in;
   logic item_valid_ff, item_valid_in;
   logic load, accept;

   assign req_stall = item_valid_ff && !load;
   assign accept = req_valid && !req_stall;

   always_comb begin
      item_in = item_ff;
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_in = req_payload;
         item_valid_in = 1'b1;
      end else if (load) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   dlefr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dlefr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .item        (item_ff),
      .item_valid  (item_valid_ff),
      .load        (load),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule
